FILE: sv/icn_pkg.sv
// shared types, constants and register indexes of the convolution unit
package icn_pkg;

    localparam int MaxWidth = 256;
    localparam int IdxW     = 8;

    localparam logic [2:0] RegCoefTop = 3'd0;
    localparam logic [2:0] RegCoefMid = 3'd1;
    localparam logic [2:0] RegCoefBot = 3'd2;
    localparam logic [2:0] RegWidth   = 3'd3;
    localparam logic [2:0] RegHeight  = 3'd4;

    localparam logic [47:0] CoefEdgeReset = 48'd281389077430252;
    localparam logic [47:0] CoefMidReset  = 48'd10485760;

    // one 3x3 neighborhood, row major, top left first
    typedef logic [8:0][7:0] window_t;

    // per-item sideband carried down the pipeline
    typedef struct packed {
        logic       has_int;
        logic       has_brd;
        logic [7:0] int_row;
        logic [7:0] int_col;
        logic [7:0] brd_row;
        logic [7:0] brd_col;
        logic [7:0] brd_pix;
    } side_t;

endpackage

FILE: sv/icn_filter.sv
// pipelined weighted sum, normalizing divide and clamp
module icn_filter (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  icn_pkg::window_t      win,
    input  icn_pkg::side_t        side_in,
    input  logic [143:0]          coefs,
    output logic                  out_valid,
    output icn_pkg::side_t        side_out,
    output logic [7:0]            result
);

    localparam int DivSteps = 16;

    // stage 1: products and coefficient sum
    logic [1:0]        v1_reg;
    icn_pkg::side_t    s1_reg [0:0];
    logic signed [24:0] prod_reg [9];
    logic signed [19:0] csum_reg;
    logic signed [19:0] csum_next;

    always_comb
    begin
        csum_next = '0;
        for (int i = 0; i < 9; i++)
        begin
            csum_next = csum_next + 20'(signed'(coefs[i*16 +: 16]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 9; i++)
            begin
                prod_reg[i] <= 25'(signed'({1'b0, win[i]}) * signed'(coefs[i*16 +: 16]));
            end
            csum_reg  <= csum_next;
            s1_reg[0] <= side_in;
        end
    end

    // stage 2: sum, truncation toward zero to an integer
    logic signed [28:0] acc_next;
    logic signed [24:0] int_reg;
    logic signed [19:0] csum2_reg;
    icn_pkg::side_t     s2_reg;

    always_comb
    begin
        acc_next = '0;
        for (int i = 0; i < 9; i++)
        begin
            acc_next = acc_next + 29'(prod_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // v*16 with truncation toward zero: clear low bits, bias negatives
            if (acc_next[28] && acc_next[3:0] != 4'd0)
            begin
                int_reg <= 25'((acc_next >>> 4) + 29'sd1);
            end
            else
            begin
                int_reg <= 25'(acc_next >>> 4);
            end
            csum2_reg <= csum_reg;
            s2_reg    <= s1_reg[0];
        end
    end

    // division stages: restoring division of |v*16| by |csum|, one bit per stage for bits
    // 8..0, later stages only carry; v*16 magnitude fits 29 bits; only quotients up to 255
    // matter, so quotient is saturated: if |num| >= |den|*512 the result clamps anyway
    logic [DivSteps:0]      dv_reg;
    logic [28:0]            rem_reg  [DivSteps+1];
    logic [18:0]            den_reg  [DivSteps+1];
    logic [9:0]             quo_reg  [DivSteps+1];
    logic                   neg_reg  [DivSteps+1];
    logic                   zero_reg [DivSteps+1];
    logic                   big_reg  [DivSteps+1];
    logic signed [24:0]     raw_reg  [DivSteps+1];
    icn_pkg::side_t         sd_reg   [DivSteps+1];

    logic [28:0] num_abs;
    logic [18:0] den_abs;
    logic signed [28:0] num16;

    assign num16   = 29'(int_reg) <<< 4;
    assign num_abs = num16[28] ? 29'(-num16) : num16;
    assign den_abs = csum2_reg[19] ? 19'(-csum2_reg) : 19'(csum2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= '0;
            dv_reg <= '0;
        end
        else if (en)
        begin
            v1_reg <= {v1_reg[0], in_valid};
            dv_reg <= {dv_reg[DivSteps-1:0], v1_reg[1]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= num_abs;
            den_reg[0]  <= den_abs;
            quo_reg[0]  <= '0;
            neg_reg[0]  <= num16[28] ^ csum2_reg[19];
            zero_reg[0] <= (csum2_reg == '0);
            big_reg[0]  <= ({10'd0, num_abs} >= ({20'd0, den_abs} << 9));
            raw_reg[0]  <= int_reg;
            sd_reg[0]   <= s2_reg;
            for (int k = 0; k < DivSteps; k++)
            begin
                den_reg[k+1]  <= den_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
                zero_reg[k+1] <= zero_reg[k];
                big_reg[k+1]  <= big_reg[k];
                raw_reg[k+1]  <= raw_reg[k];
                sd_reg[k+1]   <= sd_reg[k];
                if (k < 9 && {11'd0, rem_reg[k]} >= ({21'd0, den_reg[k]} << (8 - k)))
                begin
                    rem_reg[k+1] <= 29'({11'd0, rem_reg[k]} - ({21'd0, den_reg[k]} << (8 - k)));
                    quo_reg[k+1] <= quo_reg[k] | (10'd1 << (8 - k));
                end
                else
                begin
                    rem_reg[k+1] <= rem_reg[k];
                    quo_reg[k+1] <= quo_reg[k];
                end
            end
        end
    end

    // final: sign, clamp
    logic [7:0] res_reg;
    logic       ov_reg;
    icn_pkg::side_t so_reg;
    logic [7:0] res_next;

    always_comb
    begin
        if (zero_reg[DivSteps])
        begin
            if (raw_reg[DivSteps] < 0)
            begin
                res_next = 8'd0;
            end
            else if (raw_reg[DivSteps] > 25'sd255)
            begin
                res_next = 8'd255;
            end
            else
            begin
                res_next = raw_reg[DivSteps][7:0];
            end
        end
        else if (neg_reg[DivSteps])
        begin
            res_next = 8'd0;
        end
        else if (big_reg[DivSteps] || quo_reg[DivSteps] > 10'd255)
        begin
            res_next = 8'd255;
        end
        else
        begin
            res_next = quo_reg[DivSteps][7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            ov_reg <= dv_reg[DivSteps];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
            so_reg  <= sd_reg[DivSteps];
        end
    end

    assign out_valid = ov_reg;
    assign side_out  = so_reg;
    assign result    = res_reg;

endmodule

FILE: sv/image_convolution_3x3_normalized_unit.sv
// top level of the streaming 3x3 normalized convolution filter
// throughput: one pixel per cycle while the output is taken; an input making two results
//   sends two output beats, and the input side stalls while the first of them is outstanding
// line stores are two 256x8 memories with one read and one write per cycle
// reset: async active low, clears position, window, pipeline valids and
//   restores default coefficients and 256x256 frame size
module image_convolution_3x3_normalized_unit (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data,
    // input stream: tdata = pixel_in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    // output stream: tdata = out_row, out_col, pixel_out (lowest first)
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    output logic        m_tlast
);

    logic [47:0] coef_reg [3];
    logic [8:0]  width_reg;
    logic [8:0]  height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg[0] <= icn_pkg::CoefEdgeReset;
            coef_reg[1] <= icn_pkg::CoefMidReset;
            coef_reg[2] <= icn_pkg::CoefEdgeReset;
            width_reg   <= 9'd256;
            height_reg  <= 9'd256;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                icn_pkg::RegCoefTop: coef_reg[0] <= cfg_data;
                icn_pkg::RegCoefMid: coef_reg[1] <= cfg_data;
                icn_pkg::RegCoefBot: coef_reg[2] <= cfg_data;
                icn_pkg::RegWidth:   width_reg   <= cfg_data[8:0];
                icn_pkg::RegHeight:  height_reg  <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // effective size, clamped to 3..256
    logic [8:0] w_eff;
    logic [8:0] h_eff;
    assign w_eff = (width_reg < 9'd3) ? 9'd3 : ((width_reg > 9'd256) ? 9'd256 : width_reg);
    assign h_eff = (height_reg < 9'd3) ? 9'd3 : ((height_reg > 9'd256) ? 9'd256 : height_reg);

    // pipeline advances when the output buffer can take what comes out
    logic en;
    logic in_acc;

    // ---- stage A: accept pixel, read line stores, decide result kinds
    logic [7:0] row_reg;
    logic [7:0] col_reg;
    logic [7:0] line_a [icn_pkg::MaxWidth];
    logic [7:0] line_b [icn_pkg::MaxWidth];
    logic [7:0] top_reg;
    logic [7:0] mid_reg;
    logic [7:0] pix_reg;
    logic       va_reg;
    icn_pkg::side_t sa_reg;
    icn_pkg::side_t sa_next;

    logic last_col;
    logic last_row;
    assign last_col = {1'b0, col_reg} >= w_eff - 9'd1;
    assign last_row = {1'b0, row_reg} >= h_eff - 9'd1;

    always_comb
    begin
        sa_next.has_int = (row_reg >= 8'd2) && (col_reg >= 8'd2)
                        && ({1'b0, row_reg} <= h_eff - 9'd1)
                        && ({1'b0, col_reg} <= w_eff - 9'd1);
        sa_next.has_brd = (row_reg == 8'd0) || (col_reg == 8'd0) || last_row || last_col;
        sa_next.int_row = row_reg - 8'd1;
        sa_next.int_col = col_reg - 8'd1;
        sa_next.brd_row = row_reg;
        sa_next.brd_col = col_reg;
        sa_next.brd_pix = s_tdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
            va_reg  <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_acc;
            if (in_acc)
            begin
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? 8'd0 : row_reg + 8'd1;
                end
                else
                begin
                    col_reg <= col_reg + 8'd1;
                end
            end
        end
    end

    // line store memories: registered read, write-through forward handled
    // by construction since each column is read then written in one beat
    always_ff @(posedge clk)
    begin
        if (en && in_acc)
        begin
            top_reg <= line_b[col_reg];
            mid_reg <= line_a[col_reg];
            line_a[col_reg] <= s_tdata;
            pix_reg <= s_tdata;
            sa_reg  <= sa_next;
        end
    end

    // top-row store b gets the old a value from mid_reg, written at wb_addr_reg when en and wb_pend_reg are set
    logic       wb_pend_reg;
    logic [7:0] wb_addr_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_pend_reg <= 1'b0;
        end
        else if (en)
        begin
            wb_pend_reg <= in_acc;
        end
    end
    always_ff @(posedge clk)
    begin
        if (en && in_acc)
        begin
            wb_addr_reg <= col_reg;
        end
        if (en && wb_pend_reg)
        begin
            line_b[wb_addr_reg] <= mid_reg;
        end
    end

    // ---- stage B: window shift, form the 3x3 neighborhood
    logic [7:0] win_reg [6];
    icn_pkg::window_t win;

    always_comb
    begin
        win[0] = win_reg[0]; win[1] = win_reg[1]; win[2] = top_reg;
        win[3] = win_reg[2]; win[4] = win_reg[3]; win[5] = mid_reg;
        win[6] = win_reg[4]; win[7] = win_reg[5]; win[8] = pix_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (en && va_reg)
        begin
            win_reg[0] <= win_reg[1]; win_reg[1] <= top_reg;
            win_reg[2] <= win_reg[3]; win_reg[3] <= mid_reg;
            win_reg[4] <= win_reg[5]; win_reg[5] <= pix_reg;
        end
    end

    // same column read and written on adjacent beats: a beat at column c
    // reads line_b[c] one store after b was written, fine since rows differ

    logic           fv;
    icn_pkg::side_t fs;
    logic [7:0]     fres;

    icn_filter u_filter (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (va_reg),
        .win       (win),
        .side_in   (sa_reg),
        .coefs     ({coef_reg[2], coef_reg[1], coef_reg[0]}),
        .out_valid (fv),
        .side_out  (fs),
        .result    (fres)
    );

    // ---- output buffer: holds one item's up to two results
    logic           ob_full_reg;
    logic           ob_first_reg;
    icn_pkg::side_t ob_side_reg;
    logic [7:0]     ob_res_reg;
    logic           ob_take_int;
    logic           ob_two;
    logic           pop;
    logic           drain;

    assign ob_two      = ob_side_reg.has_int && ob_side_reg.has_brd;
    assign ob_take_int = ob_first_reg && ob_side_reg.has_int;
    assign pop         = m_tvalid && m_tready;
    // buffer is empty or empties this cycle
    assign drain       = !ob_full_reg || (pop && !(ob_two && ob_first_reg));
    assign en          = drain;
    assign s_tready    = en;
    assign in_acc      = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ob_full_reg  <= 1'b0;
            ob_first_reg <= 1'b1;
        end
        else if (en)
        begin
            ob_full_reg  <= fv && (fs.has_int || fs.has_brd);
            ob_first_reg <= 1'b1;
        end
        else if (pop)
        begin
            ob_first_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ob_side_reg <= fs;
            ob_res_reg  <= fres;
        end
    end

    assign m_tvalid = ob_full_reg;
    assign m_tlast  = !(ob_two && ob_first_reg);
    assign m_tdata  = ob_take_int
                    ? {ob_res_reg, ob_side_reg.int_col, ob_side_reg.int_row}
                    : {ob_side_reg.brd_pix, ob_side_reg.brd_col, ob_side_reg.brd_row};

`ifndef NO_ASSERTIONS
    // a two-result item keeps the buffer after its first beat
    a_two_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && ob_two && ob_first_reg) |=> (m_tvalid && !ob_first_reg))
        else $error("second result of a pair lost");

    // input side never advances while a pair's first beat is outstanding
    a_no_accept_mid_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (ob_full_reg && ob_two && ob_first_reg) |-> !s_tready)
        else $error("input taken before pair drained");

    // a held result beat keeps its data while stalled
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("output changed under stall");
`endif

endmodule

FILE: tb/tb_image_convolution_3x3_normalized_unit.sv
// self-checking testbench of the streaming 3x3 normalized convolution unit
`timescale 1ns / 1ps

module tb_image_convolution_3x3_normalized_unit;

    // one result beat as the block should send it
    typedef struct {
        logic [7:0] row;
        logic [7:0] col;
        logic [7:0] pix;
        logic       last;
    } out_beat_t;

    // one row of the directed frame table
    typedef struct {
        logic [7:0] pix;
        bit         typed;
        logic [7:0] want;
    } frame_row_t;

    localparam int StallLimit = 5000;
    localparam int HoldCycles = 300;
    localparam int SettleCycles = 30;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [47:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tlast;

    // private copy of the block state
    logic [47:0] coef_rows [3];
    logic [8:0]  frame_w;
    logic [8:0]  frame_h;
    logic [7:0]  prev_line [256];
    logic [7:0]  older_line [256];
    logic [7:0]  win [6];
    int          row_pos;
    int          col_pos;

    out_beat_t   pending_q [$];
    int          errors;
    int          stall_cnt;
    int          rand_items;
    bit          idle_on;
    bit          hold_req;
    int          hold_left;

    frame_row_t  frame_tbl [18];

    image_convolution_3x3_normalized_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        errors++;
    endtask

    // weighted 3x3 sum, normalized by the coefficient sum, clamped to a byte
    function automatic logic [7:0] filtered(input logic [7:0] px [3][3]);
        longint acc;
        longint csum;
        longint pv;
        longint kv;
        logic signed [15:0] k;
        acc = 0;
        csum = 0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                k = coef_rows[i][16*j +: 16];
                pv = px[i][j];
                kv = k;
                acc += pv * kv;
                csum += kv;
            end
        end
        acc = acc / 16;
        // zero coefficient sum: clamp the raw weighted value
        if (csum != 0)
            acc = (acc * 16) / csum;
        if (acc < 0)
            return 8'd0;
        if (acc > 255)
            return 8'd255;
        return acc[7:0];
    endfunction

    // advance the private copy by one accepted pixel, queue its results
    task automatic predict_pixel(input logic [7:0] p, input bit typed, input logic [7:0] want);
        int w;
        int h;
        int r;
        int c;
        int first;
        logic [7:0] top;
        logic [7:0] mid;
        logic [7:0] px [3][3];
        out_beat_t b;
        w = (frame_w < 3) ? 3 : ((frame_w > 256) ? 256 : frame_w);
        h = (frame_h < 3) ? 3 : ((frame_h > 256) ? 256 : frame_h);
        r = row_pos;
        c = col_pos;
        top = older_line[c];
        mid = prev_line[c];
        first = pending_q.size();
        // interior result for the pixel one row up and one column left
        if (r >= 2 && c >= 2 && r - 1 <= h - 2 && c - 1 <= w - 2)
        begin
            px[0][0] = win[0]; px[0][1] = win[1]; px[0][2] = top;
            px[1][0] = win[2]; px[1][1] = win[3]; px[1][2] = mid;
            px[2][0] = win[4]; px[2][1] = win[5]; px[2][2] = p;
            b.row = 8'(r - 1);
            b.col = 8'(c - 1);
            b.pix = filtered(px);
            b.last = 1'b0;
            pending_q.push_back(b);
        end
        // border pixels, positions past the size included, are copied
        if (r == 0 || c == 0 || r >= h - 1 || c >= w - 1)
        begin
            b.row = 8'(r);
            b.col = 8'(c);
            b.pix = typed ? want : p;
            b.last = 1'b0;
            pending_q.push_back(b);
        end
        if (pending_q.size() > first)
            pending_q[pending_q.size() - 1].last = 1'b1;
        older_line[c] = mid;
        prev_line[c] = p;
        win[0] = win[1]; win[1] = top;
        win[2] = win[3]; win[3] = mid;
        win[4] = win[5]; win[5] = p;
        if (c >= w - 1)
        begin
            col_pos = 0;
            row_pos = (r >= h - 1) ? 0 : ((r + 1) & 255);
        end
        else
        begin
            col_pos = (c + 1) & 255;
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [47:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            icn_pkg::RegCoefTop: coef_rows[0] = data;
            icn_pkg::RegCoefMid: coef_rows[1] = data;
            icn_pkg::RegCoefBot: coef_rows[2] = data;
            icn_pkg::RegWidth:   frame_w = data[8:0];
            icn_pkg::RegHeight:  frame_h = data[8:0];
            default:    ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_pixel(input logic [7:0] p, input bit typed, input logic [7:0] want);
        if (idle_on)
        begin
            while ($urandom_range(99) < 32)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata <= p;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_pixel(p, typed, want);
    endtask

    // pause the sender until every queued result is out, then let it settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    function automatic logic [7:0] rand_pixel();
        case ($urandom_range(9))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [15:0] small_coef();
        return 16'($signed($urandom_range(256)) - 128);
    endfunction

    // receiver: check each beat, then pick the next tready
    initial
    begin
        m_tready = 1'b0;
        hold_left = 0;
        forever
        begin
            out_beat_t b;
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (pending_q.size() == 0)
                begin
                    report("unexpected beat, row", m_tdata[7:0], -1);
                end
                else
                begin
                    b = pending_q.pop_front();
                    if (m_tdata[7:0] !== b.row)
                        report("out_row", m_tdata[7:0], b.row);
                    if (m_tdata[15:8] !== b.col)
                        report("out_col", m_tdata[15:8], b.col);
                    if (m_tdata[23:16] !== b.pix)
                        report("pixel_out", m_tdata[23:16], b.pix);
                    if (m_tlast !== b.last)
                        report("last_of_run", m_tlast, b.last);
                end
            end
            // long hold-off so the pipeline fills and backs up the input
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HoldCycles;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= !idle_on || ($urandom_range(99) >= 32);
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= StallLimit)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        int frames;
        int ww;
        int hh;
        logic [15:0] k [9];
        logic [15:0] ksum;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = icn_pkg::RegCoefTop;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        errors = 0;
        stall_cnt = 0;
        rand_items = 0;
        idle_on = 1'b1;
        hold_req = 1'b0;
        coef_rows[0] = icn_pkg::CoefEdgeReset;
        coef_rows[1] = icn_pkg::CoefMidReset;
        coef_rows[2] = icn_pkg::CoefEdgeReset;
        frame_w = 9'd256;
        frame_h = 9'd256;
        for (int i = 0; i < 256; i++)
        begin
            prev_line[i] = '0;
            older_line[i] = '0;
        end
        for (int i = 0; i < 6; i++)
            win[i] = '0;
        row_pos = 0;
        col_pos = 0;

        // two 3x3 frames under the reset kernel; border beats are plain copies
        frame_tbl = '{
            '{8'd0,   1, 8'd0},   '{8'd255, 1, 8'd255}, '{8'd0,   1, 8'd0},
            '{8'd255, 1, 8'd255}, '{8'd128, 0, 8'd0},   '{8'd255, 1, 8'd255},
            '{8'd0,   1, 8'd0},   '{8'd255, 1, 8'd255}, '{8'd0,   1, 8'd0},
            '{8'd255, 1, 8'd255}, '{8'd255, 1, 8'd255}, '{8'd255, 1, 8'd255},
            '{8'd255, 1, 8'd255}, '{8'd255, 0, 8'd0},   '{8'd255, 1, 8'd255},
            '{8'd255, 1, 8'd255}, '{8'd255, 1, 8'd255}, '{8'd255, 1, 8'd255}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(icn_pkg::RegWidth, 48'd3);
        write_reg(icn_pkg::RegHeight, 48'd3);
        foreach (frame_tbl[i])
            send_pixel(frame_tbl[i].pix, frame_tbl[i].typed, frame_tbl[i].want);
        drain();

        // shrink the frame mid-way so the position lies past the new size
        write_reg(icn_pkg::RegWidth, 48'd10);
        write_reg(icn_pkg::RegHeight, 48'd8);
        for (int i = 0; i < 35; i++)
            send_pixel(rand_pixel(), 0, 8'd0);
        drain();
        write_reg(icn_pkg::RegWidth, 48'd4);
        write_reg(icn_pkg::RegHeight, 48'd3);
        do
            send_pixel(rand_pixel(), 0, 8'd0);
        while (row_pos != 0 || col_pos != 0);

        for (int phase = 0; rand_items < 1240; phase++)
        begin
            drain();
            // kernel: reset values, small, full range, or zero sum
            case ($urandom_range(3))
                0:
                begin
                    write_reg(icn_pkg::RegCoefTop, icn_pkg::CoefEdgeReset);
                    write_reg(icn_pkg::RegCoefMid, icn_pkg::CoefMidReset);
                    write_reg(icn_pkg::RegCoefBot, icn_pkg::CoefEdgeReset);
                end
                1, 3:
                begin
                    ksum = '0;
                    for (int i = 0; i < 9; i++)
                    begin
                        k[i] = small_coef();
                        if (i != 4)
                            ksum += k[i];
                    end
                    if (phase % 2 == 1)
                        k[4] = -ksum;
                    write_reg(icn_pkg::RegCoefTop, {k[2], k[1], k[0]});
                    write_reg(icn_pkg::RegCoefMid, {k[5], k[4], k[3]});
                    write_reg(icn_pkg::RegCoefBot, {k[8], k[7], k[6]});
                end
                default:
                begin
                    write_reg(icn_pkg::RegCoefTop, 48'({$urandom, $urandom}));
                    write_reg(icn_pkg::RegCoefMid, 48'({$urandom, $urandom}));
                    write_reg(icn_pkg::RegCoefBot, 48'({$urandom, $urandom}));
                end
            endcase
            // sizes: widest once, then one long frame with no idling, small frames otherwise
            if (phase == 0)
            begin
                ww = 511;
                hh = 3;
            end
            else if (phase == 1)
            begin
                ww = 20;
                hh = 12;
            end
            else
            begin
                ww = ($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(3, 20);
                hh = ($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(3, 12);
            end
            write_reg(icn_pkg::RegWidth, 48'(ww));
            write_reg(icn_pkg::RegHeight, 48'(hh));
            idle_on = (phase != 1);
            if (phase == 0)
                hold_req = 1'b1;
            frames = (phase < 2) ? 1 : $urandom_range(1, 2);
            for (int f = 0; f < frames; f++)
            begin
                do
                begin
                    send_pixel(rand_pixel(), 0, 8'd0);
                    rand_items++;
                end
                while (row_pos != 0 || col_pos != 0);
            end
        end

        drain();
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: filelist.f
sv/icn_pkg.sv
sv/icn_filter.sv
sv/image_convolution_3x3_normalized_unit.sv
tb/tb_image_convolution_3x3_normalized_unit.sv
